### hdl/sllgs_pkg.sv
// Shared types, constants and register codes for the stereo glitch smoother.
`default_nettype none

package sllgs_pkg;

   // Sample width and derived arithmetic widths
   localparam int SMP_W   = 24;
   localparam int D2_W    = SMP_W + 2;                       // second difference
   localparam int DIFF_W  = SMP_W + 1;                       // cur minus older
   localparam int GAIN_W  = 16;
   localparam int PROD_W  = DIFF_W + GAIN_W + 1;             // signed product
   localparam int SCL_W   = PROD_W - GAIN_W;                 // product after Q16 floor
   localparam int REPL_W  = SCL_W + 1;                       // prev plus scaled term
   localparam int LVL_W   = 23;
   localparam int THR_W   = 25;
   localparam int CMP_W   = ((D2_W > THR_W) ? D2_W : THR_W) + 1;

   // Configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Saturation limits of the signed sample range
   localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
   localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

   // Register reset values
   localparam logic [LVL_W-1:0]  LOW_LEVEL_RST  = LVL_W'(419);
   localparam logic [LVL_W-1:0]  HIGH_LEVEL_RST = LVL_W'(8389);
   localparam logic [THR_W-1:0]  JUMP_THR_RST   = THR_W'(4194);
   localparam logic [GAIN_W-1:0] BLEND_GAIN_RST = GAIN_W'(29491);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LOW_LEVEL      = 3'd0,
      REG_HIGH_LEVEL     = 3'd1,
      REG_JUMP_THRESHOLD = 3'd2,
      REG_BLEND_GAIN     = 3'd3
   } csr_idx_type;

   // Register file contents as seen by the lanes
   typedef struct packed {
      logic [LVL_W-1:0]  low_level;
      logic [LVL_W-1:0]  high_level;
      logic [THR_W-1:0]  jump_threshold;
      logic [GAIN_W-1:0] blend_gain;
   } cfg_type;

   // Result of one lane for one word
   typedef struct packed {
      logic signed [SMP_W-1:0] value;
      logic                    fixed;
   } lane_res_type;

   // Handshake status from the output stage
   typedef struct packed {
      logic out_valid;
      logic in_ready;
   } merge_stat_type;

endpackage

`default_nettype wire

### hdl/sllgs_if.sv
// Channel interfaces for input frames, results and register writes.
`default_nettype none

interface sllgs_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sllgs_pkg::SMP_W-1:0]  left_sample;
   logic signed [sllgs_pkg::SMP_W-1:0]  right_sample;
   logic                                block_end;

   modport source (output valid, left_sample, right_sample, block_end, input ready);
   modport sink   (input valid, left_sample, right_sample, block_end, output ready);
endinterface

interface sllgs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [sllgs_pkg::SMP_W-1:0]  left_out;
   logic signed [sllgs_pkg::SMP_W-1:0]  right_out;
   logic                                left_fixed;
   logic                                right_fixed;
   logic                                block_end_out;

   modport source (output valid, left_out, right_out, left_fixed, right_fixed,
                   block_end_out, input ready);
   modport sink   (input valid, left_out, right_out, left_fixed, right_fixed,
                   block_end_out, output ready);
endinterface

interface sllgs_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [sllgs_pkg::CSR_IDX_W-1:0]      index;
   logic [sllgs_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/sllgs_lane.sv
// One channel of the smoother: level window, jump detect, blend and history.
`default_nettype none

module sllgs_lane (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic signed [sllgs_pkg::SMP_W-1:0] cur,
   input  wire sllgs_pkg::cfg_type                 cfg,
   output sllgs_pkg::lane_res_type                 res
);

   localparam int W = sllgs_pkg::SMP_W;
   localparam int D2W = sllgs_pkg::D2_W;
   localparam int DW = sllgs_pkg::DIFF_W;
   localparam int PW = sllgs_pkg::PROD_W;
   localparam int GW = sllgs_pkg::GAIN_W;
   localparam int RW = sllgs_pkg::REPL_W;
   localparam int CW = sllgs_pkg::CMP_W;

   logic signed [W-1:0]   prev_ff, prev_in;
   logic signed [W-1:0]   older_ff, older_in;
   logic        [W-1:0]   cur_mag;
   logic                  in_window;
   logic signed [D2W-1:0] d2;
   logic        [D2W-1:0] d2_mag;
   logic                  jump;
   logic signed [DW-1:0]  diff;
   logic signed [GW:0]    gain_s;
   logic signed [PW-1:0]  prod;
   logic signed [PW-GW-1:0] scaled;
   logic signed [RW-1:0]  repl;
   logic signed [W-1:0]   repl_sat;

   // Level window on the sample magnitude; most negative value maps to 2^(W-1)
   always_comb begin
      cur_mag   = cur[W-1] ? W'(-cur) : W'(cur);
      in_window = (CW'(cur_mag) > CW'(cfg.low_level)) &&
                  (CW'(cur_mag) < CW'(cfg.high_level));
   end

   // Second difference and its magnitude
   always_comb begin
      d2     = D2W'(cur) - (D2W'(prev_ff) <<< 1) + D2W'(older_ff);
      d2_mag = d2[D2W-1] ? D2W'(-d2) : D2W'(d2);
      jump   = CW'(d2_mag) > CW'(cfg.jump_threshold);
   end

   // Blend: prev plus floored Q0.16 gain times (cur - older), then saturate
   always_comb begin
      diff   = DW'(cur) - DW'(older_ff);
      gain_s = $signed({1'b0, cfg.blend_gain});
      prod   = PW'(diff) * PW'(gain_s);
      scaled = $signed(prod[PW-1:GW]);
      repl   = RW'(prev_ff) + RW'(scaled);
      if (repl > RW'(sllgs_pkg::SMP_MAX)) begin
         repl_sat = sllgs_pkg::SMP_MAX;
      end else if (repl < RW'(sllgs_pkg::SMP_MIN)) begin
         repl_sat = sllgs_pkg::SMP_MIN;
      end else begin
         repl_sat = W'(repl);
      end
   end

   // Select result and shift history
   always_comb begin
      res.fixed = in_window && jump;
      res.value = res.fixed ? repl_sat : cur;
      older_in  = advance ? prev_ff   : older_ff;
      prev_in   = advance ? res.value : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         older_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         older_ff <= older_in;
      end
   end

endmodule

`default_nettype wire

### hdl/sllgs_merge.sv
// Output stage: joins both lane results and the block marker into one held word.
`default_nettype none

module sllgs_merge (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic                    out_ready,
   input  wire sllgs_pkg::lane_res_type left_res,
   input  wire sllgs_pkg::lane_res_type right_res,
   input  wire logic                    block_end,
   output sllgs_pkg::merge_stat_type    stat,
   output sllgs_pkg::lane_res_type      left_q,
   output sllgs_pkg::lane_res_type      right_q,
   output logic                         block_end_q
);

   logic                    valid_ff, valid_in;
   sllgs_pkg::lane_res_type left_ff, left_in;
   sllgs_pkg::lane_res_type right_ff, right_in;
   logic                    blk_ff, blk_in;

   // Load on accept, drop when taken, hold otherwise
   always_comb begin
      stat.out_valid = valid_ff;
      stat.in_ready  = !valid_ff || out_ready;
      valid_in = accept ? 1'b1 : (valid_ff && !out_ready);
      left_in  = accept ? left_res  : left_ff;
      right_in = accept ? right_res : right_ff;
      blk_in   = accept ? block_end : blk_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      blk_ff   <= blk_in;
   end

   assign left_q      = left_ff;
   assign right_q     = right_ff;
   assign block_end_q = blk_ff;

endmodule

`default_nettype wire

### hdl/stereo_low_level_glitch_smoother_top.sv
// Top level of the stereo low-level glitch smoother.
//
//   channel  dir  word                                      accepted when
//   req_ch   in   left_sample, right_sample, block_end      valid & ready
//   rsp_ch   out  left_out, right_out, *_fixed, block_end   valid & ready
//   csr_ch   in   index, data (register write)              valid & ready (always ready)
//
// One frame per cycle while the output register is not stalled: both lanes compute a
// frame in the cycle it is accepted and the result sits in the output register in the next cycle.
// The per-lane history feedback (prev/older) closes through one multiplier.
// A stalled result blocks input only while the output register is full and not taken.
// Synchronous reset clears history, output valid and registers to their defaults.
`default_nettype none

module stereo_low_level_glitch_smoother_top (
   input wire logic     clock,
   input wire logic     reset,
   sllgs_req_if.sink    req_ch,
   sllgs_rsp_if.source  rsp_ch,
   sllgs_csr_if.sink    csr_ch
);

   sllgs_pkg::cfg_type        cfg_ff, cfg_in;
   sllgs_pkg::lane_res_type   left_res, right_res, left_q, right_q;
   sllgs_pkg::merge_stat_type stat;
   logic                      accept;
   logic                      block_end_q;

   // Register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (sllgs_pkg::csr_idx_type'(csr_ch.index))
            sllgs_pkg::REG_LOW_LEVEL:
               cfg_in.low_level = csr_ch.data[sllgs_pkg::LVL_W-1:0];
            sllgs_pkg::REG_HIGH_LEVEL:
               cfg_in.high_level = csr_ch.data[sllgs_pkg::LVL_W-1:0];
            sllgs_pkg::REG_JUMP_THRESHOLD:
               cfg_in.jump_threshold = csr_ch.data[sllgs_pkg::THR_W-1:0];
            sllgs_pkg::REG_BLEND_GAIN:
               cfg_in.blend_gain = csr_ch.data[sllgs_pkg::GAIN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_level      <= sllgs_pkg::LOW_LEVEL_RST;
         cfg_ff.high_level     <= sllgs_pkg::HIGH_LEVEL_RST;
         cfg_ff.jump_threshold <= sllgs_pkg::JUMP_THR_RST;
         cfg_ff.blend_gain     <= sllgs_pkg::BLEND_GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input handshake
   assign req_ch.ready = stat.in_ready;
   assign accept       = req_ch.valid && stat.in_ready;

   // Lanes
   sllgs_lane u_left (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .cur     (req_ch.left_sample),
      .cfg     (cfg_ff),
      .res     (left_res)
   );

   sllgs_lane u_right (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .cur     (req_ch.right_sample),
      .cfg     (cfg_ff),
      .res     (right_res)
   );

   // Merge and output register
   sllgs_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .out_ready   (rsp_ch.ready),
      .left_res    (left_res),
      .right_res   (right_res),
      .block_end   (req_ch.block_end),
      .stat        (stat),
      .left_q      (left_q),
      .right_q     (right_q),
      .block_end_q (block_end_q)
   );

   assign rsp_ch.valid         = stat.out_valid;
   assign rsp_ch.left_out      = left_q.value;
   assign rsp_ch.right_out     = right_q.value;
   assign rsp_ch.left_fixed    = left_q.fixed;
   assign rsp_ch.right_fixed   = right_q.fixed;
   assign rsp_ch.block_end_out = block_end_q;

endmodule

`default_nettype wire

### hdl/sllgs_checker.sv
// Port-level checks for the smoother top, attached by bind.
`default_nettype none

module sllgs_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [sllgs_pkg::SMP_W-1:0] rsp_left_out
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_out))
      else $error("stalled result dropped or changed");

   // Every accepted frame shows up as a result on the next cycle
   a_accept_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted frame produced no result");

   // An empty output register never blocks input
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // Reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stereo_low_level_glitch_smoother_top sllgs_checker u_sllgs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_left_out (rsp_ch.left_out)
);

`default_nettype wire
